### design/rct_pkg.sv
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types and constants for the rate cluster table.
// ----------------------------------------------------------------------------
package rct_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int RATE_W          = 32;
	localparam int WEIGHT_W        = 32;
	localparam int SWEIGHT_W       = 16;
	localparam int DIV_W           = 11;
	localparam int STATUS_W        = 3;
	localparam int INDEX_OUT_W     = 6;
	localparam int COUNT_OUT_W     = 7;
	localparam logic [DIV_W-1:0] DIV_RESET = 11'd20;

	typedef enum logic [STATUS_W-1:0] {
		ST_IGNORED  = 3'd0,
		ST_MATCHED  = 3'd1,
		ST_APPENDED = 3'd2,
		ST_FULL     = 3'd3,
		ST_CLEARED  = 3'd4
	} rct_status_t;

	// search word travelling down the row of cells
	typedef struct packed {
		logic                valid;
		logic                have;
		logic [RATE_W-1:0]   rate;
		logic [RATE_W-1:0]   gap;
		logic [WEIGHT_W-1:0] weight;
	} rct_token_t;

	// write command broadcast to all cells
	typedef struct packed {
		logic                en;
		logic                set_rate;
		logic [RATE_W-1:0]   rate;
		logic [WEIGHT_W-1:0] weight;
	} rct_wr_t;

endpackage

### design/rct_cell.sv
// ----------------------------------------------------------------------------
// rct_cell
// One table entry plus one step of the nearest-rate search.
// ----------------------------------------------------------------------------
module rct_cell import rct_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int POS         = 0,
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CW-1:0] used,
	input  rct_token_t    tok_in,
	input  logic [IW-1:0] idx_in,
	output rct_token_t    tok_out,
	output logic [IW-1:0] idx_out,
	input  rct_wr_t       wr,
	input  logic [IW-1:0] wr_idx
);

	logic [RATE_W-1:0]   rate_q;
	logic [WEIGHT_W-1:0] weight_q;
	rct_token_t          tok_q;
	logic [IW-1:0]       idx_q;
	rct_token_t          tok_n;
	logic [IW-1:0]       idx_n;
	logic [RATE_W-1:0]   diff;
	logic                active;
	logic                take;

	assign diff   = (rate_q >= tok_in.rate) ? (rate_q - tok_in.rate) : (tok_in.rate - rate_q);
	// only entries below the fill count hold written data
	assign active = tok_in.valid && (CW'(POS) < used);
	// strict compare keeps the lower index on a tie
	assign take   = active && (!tok_in.have || (diff < tok_in.gap));

	always_comb begin
		tok_n = tok_in;
		idx_n = idx_in;
		if (take) begin
			tok_n.have   = 1'b1;
			tok_n.gap    = diff;
			tok_n.weight = weight_q;
			idx_n        = IW'(POS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			idx_q <= '0;
		end else begin
			tok_q <= tok_n;
			idx_q <= idx_n;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr_idx == IW'(POS))) begin
			weight_q <= wr.weight;
			if (wr.set_rate) begin
				rate_q <= wr.rate;
			end
		end
	end

	assign tok_out = tok_q;
	assign idx_out = idx_q;

endmodule

### design/rate_cluster_table.sv
// ----------------------------------------------------------------------------
// rate_cluster_table
// Clusters rate samples into a table of weighted rates, one cell per entry.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_stall   kind, sample_rate, sample_weight
//  out      out_valid / out_stall status, entry_index, entry_weight, entries_in_use
//  cfg      cfg_valid / cfg_ready tolerance_divisor
//
//  a search item: the word walks the whole row of cells, each cell a register
//  stage, then the tolerance multiply is registered and the result is committed
//  clear, zero rate and empty table items skip the walk and the multiply
//  one item in work at a time; the output register lets the next item in
//  while a result waits under out_stall
//  reset clears fill count and control only; entries are written before read
// ----------------------------------------------------------------------------
module rate_cluster_table import rct_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   kind,
	input  logic [RATE_W-1:0]      sample_rate,
	input  logic [SWEIGHT_W-1:0]   sample_weight,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [STATUS_W-1:0]    status,
	output logic [INDEX_OUT_W-1:0] entry_index,
	output logic [WEIGHT_W-1:0]    entry_weight,
	output logic [COUNT_OUT_W-1:0] entries_in_use,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [DIV_W-1:0]       tolerance_divisor
);

	localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int PW   = RATE_W + DIV_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_MULT = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [DIV_W-1:0]     div_q;
	logic [CW-1:0]        used_q;
	logic                 kind_q;
	logic [RATE_W-1:0]    rate_q;
	logic [SWEIGHT_W-1:0] wt_q;
	logic [RATE_W-1:0]    bdist_q;
	logic [WEIGHT_W-1:0]  bw_q;
	logic [IW-1:0]        bidx_q;
	logic [PW-1:0]        prod_q;
	rct_token_t           inj_q;

	logic                   out_valid_q;
	rct_status_t            status_q;
	logic [INDEX_OUT_W-1:0] index_q;
	logic [WEIGHT_W-1:0]    eweight_q;
	logic [COUNT_OUT_W-1:0] count_q;

	rct_token_t    tok [0:TABLE_DEPTH];
	logic [IW-1:0] tidx [0:TABLE_DEPTH];
	rct_wr_t       wr;
	logic [IW-1:0] wr_idx;

	logic                in_acc;
	logic                fire;
	logic                quick;
	logic                match;
	logic [WEIGHT_W:0]   sum;
	logic [WEIGHT_W-1:0] sat;
	rct_status_t         res_status;
	logic [IW-1:0]       res_idx;
	logic [WEIGHT_W-1:0] res_weight;
	logic [CW-1:0]       used_n;
	logic [31:0]         idx_ext;
	logic [31:0]         cnt_ext;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign fire      = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign quick     = kind || (sample_rate == '0) || (used_q == '0);

	assign tok[0]  = inj_q;
	assign tidx[0] = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		rct_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.POS        (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.used   (used_q),
			.tok_in (tok[i]),
			.idx_in (tidx[i]),
			.tok_out(tok[i+1]),
			.idx_out(tidx[i+1]),
			.wr     (wr),
			.wr_idx (wr_idx)
		);
	end

	assign match = prod_q < PW'(rate_q);
	assign sum   = {1'b0, bw_q} + (WEIGHT_W+1)'(wt_q);
	assign sat   = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];

	always_comb begin
		res_status = ST_IGNORED;
		res_idx    = '0;
		res_weight = '0;
		used_n     = used_q;
		wr         = '0;
		wr_idx     = '0;
		if (kind_q) begin
			res_status = ST_CLEARED;
			used_n     = '0;
		end else if (rate_q == '0) begin
			res_status = ST_IGNORED;
		end else if (used_q == '0) begin
			// first entry starts at weight one
			res_status  = ST_APPENDED;
			res_weight  = WEIGHT_W'(1);
			used_n      = CW'(1);
			wr.en       = 1'b1;
			wr.set_rate = 1'b1;
			wr.rate     = rate_q;
			wr.weight   = WEIGHT_W'(1);
		end else if (match) begin
			res_status = ST_MATCHED;
			res_idx    = bidx_q;
			res_weight = sat;
			wr.en      = 1'b1;
			wr.weight  = sat;
			wr_idx     = bidx_q;
		end else if (used_q == CW'(TABLE_DEPTH)) begin
			res_status = ST_FULL;
		end else begin
			res_status  = ST_APPENDED;
			res_idx     = used_q[IW-1:0];
			res_weight  = WEIGHT_W'(wt_q);
			used_n      = used_q + CW'(1);
			wr.en       = 1'b1;
			wr.set_rate = 1'b1;
			wr.rate     = rate_q;
			wr.weight   = WEIGHT_W'(wt_q);
			wr_idx      = used_q[IW-1:0];
		end
		if (!fire) begin
			wr.en = 1'b0;
		end
	end

	assign idx_ext = 32'(res_idx);
	assign cnt_ext = 32'(used_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_q       <= DIV_RESET;
			used_q      <= '0;
			inj_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			inj_q.valid <= in_acc && !quick;
			if (cfg_valid && cfg_ready) begin
				div_q <= tolerance_divisor;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (quick) begin
							state_q <= S_FIN;
						end else begin
							inj_q.have  <= 1'b0;
							inj_q.rate  <= sample_rate;
							state_q     <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (tok[TABLE_DEPTH].valid) begin
						state_q <= S_MULT;
					end
				end
				S_MULT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fire) begin
						used_q      <= used_n;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= kind;
			rate_q <= sample_rate;
			wt_q   <= sample_weight;
		end
		if ((state_q == S_SCAN) && tok[TABLE_DEPTH].valid) begin
			bdist_q <= tok[TABLE_DEPTH].gap;
			bw_q    <= tok[TABLE_DEPTH].weight;
			bidx_q  <= tidx[TABLE_DEPTH];
		end
		if (state_q == S_MULT) begin
			prod_q <= PW'(bdist_q) * PW'(div_q);
		end
		if (fire) begin
			status_q  <= res_status;
			index_q   <= idx_ext[INDEX_OUT_W-1:0];
			eweight_q <= res_weight;
			count_q   <= cnt_ext[COUNT_OUT_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign entry_index    = index_q;
	assign entry_weight   = eweight_q;
	assign entries_in_use = count_q;

endmodule
